// ===== sv/pts_pkg.sv =====
// shared types and constants for the pan step block
`timescale 1ns / 1ps
package pts_pkg;

  localparam int VAL_W = 64;
  localparam int WID_W = 16;
  localparam int SPD_W = 10;
  localparam int PROD_W = WID_W + SPD_W;
  localparam int PIX_W = 18;
  localparam int NUM_W = VAL_W + PIX_W;
  localparam int LANE_LAT = NUM_W + 5;
  localparam int RECIP_SHIFT = 34;
  localparam logic [PROD_W-1:0] PIX_RECIP = 26'd57266231;
  localparam logic [WID_W-1:0] WIDTH_RST = 16'd640;
  localparam logic [SPD_W-1:0] SPEED_RST = 10'd10;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SPEED  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] cur_re;
    logic signed [VAL_W-1:0] cur_im;
    logic signed [VAL_W-1:0] goal_re;
    logic signed [VAL_W-1:0] goal_im;
    logic signed [VAL_W-1:0] span_re;
    logic signed [VAL_W-1:0] span_im;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] next_re;
    logic signed [VAL_W-1:0] next_im;
    logic                    moved;
  } out_t;

  typedef struct packed {
    logic [VAL_W-1:0] cur;
    logic [VAL_W-1:0] goal;
    logic             gt;
    logic             lt;
    logic             neg;
    logic             zero;
  } lane_ctl_t;

  typedef struct packed {
    logic [WID_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    lane_ctl_t        ctl;
  } div_t;

endpackage

// ===== sv/pts_div_step.sv =====
// one restoring division step with its stage register
`timescale 1ns / 1ps
module pts_div_step import pts_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [WID_W-1:0] w,
  input  div_t             d,
  output div_t             q
);

  logic [WID_W:0] t;
  logic [WID_W:0] diff;
  logic           ge;

  always_comb begin
    t    = {d.rem, d.nq[NUM_W-1]};
    diff = t - {1'b0, w};
    ge   = (t >= {1'b0, w});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.rem <= ge ? diff[WID_W-1:0] : t[WID_W-1:0];
      q.nq  <= {d.nq[NUM_W-2:0], ge};
      q.ctl <= d.ctl;
    end
  end

endmodule

// ===== sv/pts_lane.sv =====
// one axis: step size, divide, saturating add and snap to target
`timescale 1ns / 1ps
module pts_lane import pts_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [VAL_W-1:0] cur,
  input  logic [VAL_W-1:0] goal,
  input  logic [VAL_W-1:0] span,
  input  logic [PIX_W-1:0] pix,
  input  logic [WID_W-1:0] w,
  output logic [VAL_W-1:0] nxt,
  output logic             eq
);

  lane_ctl_t          a_ctl;
  logic [VAL_W-1:0]   a_mag;
  lane_ctl_t          b_ctl;
  logic [49:0]        pp_lo;
  logic [49:0]        pp_hi;
  div_t               d_st [0:NUM_W];
  lane_ctl_t          f_ctl;
  logic [VAL_W-1:0]   f_t;
  logic               lt_in;
  logic               gt_in;
  logic [NUM_W-1:0]   qv;
  logic               big;
  logic [VAL_W-1:0]   delta;
  logic [VAL_W:0]     sum;
  logic [VAL_W-1:0]   t_sat;
  logic               gt2;
  logic               lt2;

  always_comb begin
    gt_in = $signed(goal) > $signed(cur);
    lt_in = $signed(goal) < $signed(cur);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctl.cur  <= cur;
      a_ctl.goal <= goal;
      a_ctl.gt   <= gt_in;
      a_ctl.lt   <= lt_in;
      a_ctl.neg  <= span[VAL_W-1] ^ lt_in;
      a_ctl.zero <= (w == '0);
      a_mag      <= span[VAL_W-1] ? (~span + 64'd1) : span;
    end
  end

  // split product into two narrow partial products
  always_ff @(posedge clk) begin
    if (en) begin
      b_ctl <= a_ctl;
      pp_lo <= 50'(a_mag[31:0]) * 50'(pix);
      pp_hi <= 50'(a_mag[63:32]) * 50'(pix);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_st[0].rem <= '0;
      d_st[0].nq  <= NUM_W'(pp_lo) + {pp_hi, 32'd0};
      d_st[0].ctl <= b_ctl;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    pts_div_step u_step (
      .clk (clk),
      .en  (en),
      .w   (w),
      .d   (d_st[k]),
      .q   (d_st[k+1])
    );
  end

  always_comb begin
    qv  = d_st[NUM_W].nq;
    big = |qv[NUM_W-1:VAL_W-1];
    priority if (d_st[NUM_W].ctl.zero) begin
      delta = '0;
    end else if (d_st[NUM_W].ctl.neg) begin
      delta = big ? VAL_MIN : (~qv[VAL_W-1:0] + 64'd1);
    end else begin
      delta = big ? VAL_MAX : qv[VAL_W-1:0];
    end
    sum = {d_st[NUM_W].ctl.cur[VAL_W-1], d_st[NUM_W].ctl.cur} + {delta[VAL_W-1], delta};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      t_sat = sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      t_sat = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_ctl <= d_st[NUM_W].ctl;
      f_t   <= t_sat;
    end
  end

  always_comb begin
    gt2 = $signed(f_ctl.goal) > $signed(f_t);
    lt2 = $signed(f_ctl.goal) < $signed(f_t);
  end

  // snap when the step lands on or past the target
  always_ff @(posedge clk) begin
    if (en) begin
      nxt <= ((gt2 != f_ctl.gt) || (lt2 != f_ctl.lt)) ? f_ctl.goal : f_t;
      eq  <= !f_ctl.gt && !f_ctl.lt;
    end
  end

endmodule

// ===== sv/pan_step_toward_target.sv =====
// top level: config registers, input stage, two axis lanes and result merge
//
//   channel  handshake                 payload
//   item     item_valid / item_ready   item (in_t)
//   result   result_valid / result_ready result (out_t)
//   cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one word per cycle unless the result stalls; each word passes the input
// register, the lane registers with the 82-step divider chain and the result
// register; config step size passes the prod and pix registers; reset clears
// valid bits, sets config defaults; a stalled result holds the whole pipeline
`timescale 1ns / 1ps
module pan_step_toward_target import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_t         item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = LANE_LAT + 2;

  logic [WID_W-1:0]  frame_width;
  logic [SPD_W-1:0]  pan_speed;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  pix;
  logic [2*PROD_W-1:0] pix_full;
  logic [DEPTH-1:0]  vld;
  logic              en;
  in_t               item_q;
  logic [VAL_W-1:0]  nxt_re;
  logic [VAL_W-1:0]  nxt_im;
  logic              eq_re;
  logic              eq_im;

  assign en           = !vld[DEPTH-1] || result_ready;
  assign item_ready   = en && !rst;
  assign result_valid = vld[DEPTH-1];
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= WIDTH_RST;
      pan_speed   <= SPEED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  frame_width <= cfg_data;
        CFG_HEIGHT: ;
        CFG_SPEED:  pan_speed   <= cfg_data[SPD_W-1:0];
        default:    ;
      endcase
    end
  end

  // pixels per step, divide by 300 through a reciprocal
  assign pix_full = prod * PIX_RECIP;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(pan_speed) * PROD_W'(frame_width);
    pix  <= pix_full[RECIP_SHIFT +: PIX_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_q <= item;
    end
  end

  pts_lane u_re (
    .clk  (clk),
    .en   (en),
    .cur  (item_q.cur_re),
    .goal (item_q.goal_re),
    .span (item_q.span_re),
    .pix  (pix),
    .w    (frame_width),
    .nxt  (nxt_re),
    .eq   (eq_re)
  );

  pts_lane u_im (
    .clk  (clk),
    .en   (en),
    .cur  (item_q.cur_im),
    .goal (item_q.goal_im),
    .span (item_q.span_im),
    .pix  (pix),
    .w    (frame_width),
    .nxt  (nxt_im),
    .eq   (eq_im)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      result.next_re <= nxt_re;
      result.next_im <= nxt_im;
      result.moved   <= !(eq_re && eq_im);
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for pan_step_toward_target: directed table then random words, checked by a predictor
`timescale 1ns / 1ps
module testbench;
  import pts_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_t         item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  localparam logic signed [63:0] SMAX = 64'sh7FFFFFFFFFFFFFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000000000000000;
  localparam logic signed [63:0] ONE = 64'sh0100000000000000;

  pan_step_toward_target dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int unsigned width_reg;
  int unsigned speed_reg;
  out_t        centre_q[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          done = 0;

  function automatic logic signed [63:0] axis_step(logic signed [63:0] cur,
      logic signed [63:0] goal, logic signed [63:0] span, int unsigned pix,
      int unsigned w);
    int dir0, dir1;
    logic neg;
    logic [63:0] a, q, r, m;
    logic signed [63:0] d;
    logic signed [64:0] sum;
    logic signed [63:0] t;
    dir0 = (goal > cur) ? 1 : (goal < cur) ? -1 : 0;
    neg = (span < 0) != (dir0 < 0);
    if (w == 0 || pix == 0) begin
      d = 0;
    end else begin
      a = span[63] ? (64'd0 - span) : span;
      q = a / w;
      r = a % w;
      if (q > (64'h8000000000000000 / pix)) begin
        m = 64'h8000000000000001;
      end else begin
        m = q * pix + (r * pix) / w;
      end
      if (neg) d = (m >= 64'h8000000000000000) ? SMIN : -$signed(m);
      else d = (m > 64'h7FFFFFFFFFFFFFFF) ? SMAX : $signed(m);
    end
    sum = cur + d;
    if (sum > SMAX) t = SMAX;
    else if (sum < SMIN) t = SMIN;
    else t = sum[63:0];
    dir1 = (goal > t) ? 1 : (goal < t) ? -1 : 0;
    return (dir1 != dir0) ? goal : t;
  endfunction

  function automatic out_t pan_centre(in_t x);
    out_t o;
    int unsigned pix;
    if (x.cur_re == x.goal_re && x.cur_im == x.goal_im) begin
      o.next_re = x.cur_re;
      o.next_im = x.cur_im;
      o.moved = 1'b0;
    end else begin
      pix = (speed_reg * width_reg) / 300;
      o.next_re = axis_step(x.cur_re, x.goal_re, x.span_re, pix, width_reg);
      o.next_im = axis_step(x.cur_im, x.goal_im, x.span_im, pix, width_reg);
      o.moved = 1'b1;
    end
    return o;
  endfunction

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) width_reg = val & 16'hFFFF;
    if (idx == CFG_SPEED) speed_reg = val & 10'h3FF;
    repeat (4) @(negedge clk);
  endtask

  int gap_left = 0;
  task automatic send_word(in_t x, bit has_exp, out_t e);
    if (gap_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      gap_left = $urandom_range(1, 20);
    end
    gap_left--;
    item <= x;
    item_valid <= 1'b1;
    centre_q.push_back(has_exp ? e : pan_centre(x));
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (centre_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic signed [63:0] rnd64();
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return v;
      1: return v >>> $urandom_range(4, 60);
      2: return ($urandom_range(0, 1) ? SMAX : SMIN) - $signed(64'($urandom_range(0, 3)));
      default: return v >>> 8;
    endcase
  endfunction

  function automatic in_t rnd_word();
    in_t x;
    x.cur_re = rnd64();
    x.cur_im = rnd64();
    x.goal_re = ($urandom_range(0, 7) == 0) ? x.cur_re : x.cur_re + (rnd64() >>> 4);
    x.goal_im = ($urandom_range(0, 7) == 0) ? x.cur_im : x.cur_im + (rnd64() >>> 4);
    if ($urandom_range(0, 3) == 0) x.goal_re = rnd64();
    x.span_re = ($urandom_range(0, 4) == 0) ? rnd64() : (rnd64() >>> 2);
    x.span_im = ($urandom_range(0, 4) == 0) ? rnd64() : (rnd64() >>> 2);
    return x;
  endfunction

  typedef struct {
    in_t  x;
    bit   has_exp;
    out_t e;
  } row_t;
  row_t rows[$];

  function automatic row_t mk(in_t x, bit h, out_t e);
    row_t r;
    r.x = x;
    r.has_exp = h;
    r.e = e;
    return r;
  endfunction

  // result side
  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 9) < 7) || cycles[9];
  end

  always @(posedge clk) begin
    out_t e;
    cycles <= cycles + 1;
    if (!rst && result_valid && result_ready) begin
      if (centre_q.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, result);
        errors++;
      end else begin
        e = centre_q.pop_front();
        if (result.next_re !== e.next_re)
          $display("%0t: next_re expected %h actual %h", $time, e.next_re, result.next_re);
        if (result.next_im !== e.next_im)
          $display("%0t: next_im expected %h actual %h", $time, e.next_im, result.next_im);
        if (result.moved !== e.moved)
          $display("%0t: moved expected %b actual %b", $time, e.moved, result.moved);
        if (result !== e) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000 && !done) begin
      $display("** pan_step_toward_target: FAILED **");
      $finish;
    end
  end

  int unsigned widths[5] = '{640, 1, 65535, 0, 300};
  int unsigned speeds[5] = '{10, 0, 1000, 1023, 300};

  initial begin
    in_t  x;
    out_t e;
    width_reg = 640;
    speed_reg = 10;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    // directed table, reset settings
    x = '{ONE, -ONE, ONE, -ONE, ONE, ONE};
    e = '{ONE, -ONE, 1'b0};
    rows.push_back(mk(x, 1, e));
    x = '{SMAX, SMIN, SMAX, SMIN, SMAX, SMIN};
    e = '{SMAX, SMIN, 1'b0};
    rows.push_back(mk(x, 1, e));
    x = '{0, 0, SMAX, SMIN, SMAX, SMAX};
    rows.push_back(mk(x, 0, e));
    x = '{SMIN, SMAX, SMAX, SMIN, SMAX, SMAX};
    rows.push_back(mk(x, 0, e));
    x = '{0, 0, ONE, 0, ONE, ONE};
    rows.push_back(mk(x, 0, e));
    x = '{0, 0, -ONE, ONE, -ONE, -ONE};
    rows.push_back(mk(x, 0, e));
    x = '{0, 0, 5, -5, SMAX, SMAX};
    rows.push_back(mk(x, 0, e));
    x = '{SMAX - 3, SMIN + 3, SMAX, SMIN, SMIN, SMIN};
    rows.push_back(mk(x, 0, e));
    x = '{-1, 1, 0, 0, '1, 64'sh5555555555555555};
    rows.push_back(mk(x, 0, e));
    x = '{64'shAAAAAAAAAAAAAAAA, 64'sh5555555555555555, 0, 0, ONE, ONE};
    rows.push_back(mk(x, 0, e));
    foreach (rows[i]) send_word(rows[i].x, rows[i].has_exp, rows[i].e);
    drain();

    write_reg(CFG_HEIGHT, 65535);
    write_reg(CFG_WIDTH, 0);
    x = '{0, ONE, ONE, 0, ONE, ONE};
    e = '{0, ONE, 1'b1};
    send_word(x, 1, e);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_WIDTH, (ph < 5) ? widths[ph] : $urandom_range(1, 65535));
      write_reg(CFG_SPEED, (ph < 5) ? speeds[ph] : $urandom_range(0, 1023));
      write_reg(CFG_HEIGHT, $urandom_range(1, 65535));
      for (int n = 0; n < 100; n++) send_word(rnd_word(), 0, e);
      drain();
    end

    done = 1;
    if (errors == 0) $display("** pan_step_toward_target: PASSED **");
    else $display("** pan_step_toward_target: FAILED **");
    $finish;
  end
endmodule
